### sv/fcw_pkg.sv
// ----------------------------------------------------------------------------
// fcw_pkg
// shared types, codes and entry helpers for the fat cluster chain walker
// ----------------------------------------------------------------------------
package fcw_pkg;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_WALK = 1'b1
    } cmd_kind_t;

    // value is the load address for a load, the start cluster for a walk
    typedef struct packed
    {
        cmd_kind_t   kind;
        logic [15:0] value;
        logic [7:0]  data;
    } cmd_t;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_OOB   = 2'd1;
    localparam status_t STATUS_TRUNC = 2'd2;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_READ,
        BK_EVAL
    } back_state_t;

    localparam int          OFF_W    = 18;
    localparam logic [15:0] END16    = 16'hFFF8;
    localparam logic [11:0] END12    = 12'hFF8;
    localparam int          QDEPTH   = 2;

    function automatic logic is_end(input logic [15:0] v, input logic sixteen);
        logic r;
        if (sixteen)
        begin
            r = (v >= END16);
        end
        else
        begin
            r = (v[11:0] >= END12);
        end
        return r;
    endfunction

    function automatic logic [15:0] entry_value(input logic [15:0] w,
                                                input logic odd,
                                                input logic sixteen);
        logic [15:0] r;
        if (sixteen)
        begin
            r = w;
        end
        else if (odd)
        begin
            r = {4'b0000, w[15:4]};
        end
        else
        begin
            r = {4'b0000, w[11:0]};
        end
        return r;
    endfunction

    function automatic logic [OFF_W-1:0] entry_offset(input logic [15:0] n,
                                                      input logic sixteen);
        logic [OFF_W-1:0] r;
        if (sixteen)
        begin
            r = OFF_W'({n, 1'b0});
        end
        else
        begin
            r = OFF_W'(n) + OFF_W'(n[15:1]);
        end
        return r;
    endfunction

endpackage

### sv/fcw_front.sv
// ----------------------------------------------------------------------------
// fcw_front
// accepts input transfers, classifies them into commands, short command queue
// ----------------------------------------------------------------------------
module fcw_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_op,
    input  logic [39:0]   s_data,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output fcw_pkg::cmd_t cmd
);
    import fcw_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    cmd_t          q_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;
    cmd_t          in_cmd;

    // classify: a walk carries its start cluster, a load its address and byte
    always_comb
    begin
        in_cmd.kind = cmd_kind_t'(s_op);
        in_cmd.data = s_data[23:16];
        if (s_op == CMD_WALK)
        begin
            in_cmd.value = s_data[39:24];
        end
        else
        begin
            in_cmd.value = s_data[15:0];
        end
    end

    assign s_ready   = (count_reg != CW'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### sv/fcw_back.sv
// ----------------------------------------------------------------------------
// fcw_back
// fat byte store, chain walk sequencer and result output register
// ----------------------------------------------------------------------------
module fcw_back
#(
    parameter int STORE_BYTES = 65536,
    parameter int MAX_CHAIN   = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sixteen_bit_entries,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  fcw_pkg::cmd_t    cmd,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      out_cluster,
    output logic             out_last,
    output fcw_pkg::status_t out_status
);
    import fcw_pkg::*;

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int KW = (MAX_CHAIN > 2) ? $clog2(MAX_CHAIN) : 1;
    localparam logic [OFF_W-1:0] STORE_LIMIT = OFF_W'(STORE_BYTES);

    logic [7:0]       mem [STORE_BYTES];
    logic [7:0]       rd_lo_reg;
    logic [7:0]       rd_hi_reg;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [15:0]      cur_reg;
    logic [15:0]      cur_next;
    logic [KW-1:0]    k_reg;
    logic [KW-1:0]    k_next;
    logic             oob_reg;
    logic             oob_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [15:0]      out_cluster_reg;
    logic [15:0]      out_cluster_next;
    logic             out_last_reg;
    logic             out_last_next;
    status_t          out_status_reg;
    status_t          out_status_next;

    logic             out_free;
    logic             out_load;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr0;
    logic [AW-1:0]    raddr1;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] off_plus;
    logic [15:0]      nxt;
    logic             start_end;
    logic             nxt_end;
    logic             last_link;

    assign out_free  = !out_valid_reg || out_ready;
    assign off       = entry_offset(cur_reg, sixteen_bit_entries);
    assign off_plus  = off + 1'b1;
    assign raddr0    = AW'(off);
    assign raddr1    = AW'(off_plus);
    assign waddr     = AW'(cmd.value);
    assign nxt       = entry_value({rd_hi_reg, rd_lo_reg}, cur_reg[0], sixteen_bit_entries);
    assign start_end = is_end(cmd.value, sixteen_bit_entries);
    assign nxt_end   = is_end(nxt, sixteen_bit_entries);
    assign last_link = (k_reg == KW'(MAX_CHAIN - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && cmd.kind == CMD_WALK && out_free && !start_end)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_EVAL;
            end
            BK_EVAL:
            begin
                if (out_free)
                begin
                    if (oob_reg || nxt_end || last_link)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        state_next = BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd_ready        = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        out_load         = 1'b0;
        cur_next         = cur_reg;
        k_next           = k_reg;
        oob_next         = oob_reg;
        out_cluster_next = out_cluster_reg;
        out_last_next    = out_last_reg;
        out_status_next  = out_status_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd.kind == CMD_LOAD)
                begin
                    cmd_ready = 1'b1;
                    mem_we    = cmd_valid && (OFF_W'(cmd.value) < STORE_LIMIT);
                end
                else
                begin
                    cmd_ready = out_free;
                    if (cmd_valid && out_free)
                    begin
                        out_load         = 1'b1;
                        out_cluster_next = cmd.value;
                        out_last_next    = start_end;
                        out_status_next  = STATUS_OK;
                        cur_next         = cmd.value;
                        k_next           = KW'(1);
                    end
                end
            end
            BK_READ:
            begin
                mem_re   = 1'b1;
                oob_next = (off_plus >= STORE_LIMIT);
            end
            BK_EVAL:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (oob_reg)
                    begin
                        out_cluster_next = '0;
                        out_last_next    = 1'b1;
                        out_status_next  = STATUS_OOB;
                    end
                    else if (nxt_end)
                    begin
                        out_cluster_next = nxt;
                        out_last_next    = 1'b1;
                        out_status_next  = STATUS_OK;
                    end
                    else if (last_link)
                    begin
                        out_cluster_next = nxt;
                        out_last_next    = 1'b1;
                        out_status_next  = STATUS_TRUNC;
                    end
                    else
                    begin
                        out_cluster_next = nxt;
                        out_last_next    = 1'b0;
                        out_status_next  = STATUS_OK;
                        cur_next         = nxt;
                        k_next           = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            k_reg         <= '0;
            oob_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            k_reg         <= k_next;
            oob_reg       <= oob_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cluster_reg <= out_cluster_next;
        out_last_reg    <= out_last_next;
        out_status_reg  <= out_status_next;
    end

    // byte store, one write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= cmd.data;
        end
        if (mem_re)
        begin
            rd_lo_reg <= mem[raddr0];
            rd_hi_reg <= mem[raddr1];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_cluster = out_cluster_reg;
    assign out_last    = out_last_reg;
    assign out_status  = out_status_reg;

endmodule

### sv/fat_cluster_chain_walker.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_walker
// fat12/fat16 cluster chain walker over a loaded byte image of the table
// ----------------------------------------------------------------------------
// A load transfer writes one table byte if its address is in the store. A
// walk transfer emits the start cluster in the cycle after the sequencer
// takes it, then per chain link a registered read of both entry bytes from
// the store, then evaluation into the output register; a walk gives at most
// MAX_CHAIN results, output stalls holding it. Items are handled one at a time
// in order; a two-entry command queue lets the input side keep accepting while
// a walk runs. The store has no reset and needs no clearing pass. The user must
// write the entry mode register only while idle; the block doesn't enforce it.
module fat_cluster_chain_walker
#(
    parameter int STORE_BYTES = 65536,
    parameter int MAX_CHAIN   = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // load_address, load_byte, walk_start
    input  logic        s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // cluster
    output logic        m_axis_tlast,  // last
    output logic [1:0]  m_axis_tuser   // status
);
    import fcw_pkg::*;

    logic    sixteen_reg;
    logic    cmd_valid;
    logic    cmd_ready;
    cmd_t    cmd;
    status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sixteen_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            sixteen_reg <= cfg_wr_data;
        end
    end

    fcw_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_op      (s_axis_tuser),
        .s_data    (s_axis_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    fcw_back
    #(
        .STORE_BYTES (STORE_BYTES),
        .MAX_CHAIN   (MAX_CHAIN)
    )
    u_back
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .sixteen_bit_entries (sixteen_reg),
        .cmd_valid           (cmd_valid),
        .cmd_ready           (cmd_ready),
        .cmd                 (cmd),
        .out_valid           (m_axis_tvalid),
        .out_ready           (m_axis_tready),
        .out_cluster         (m_axis_tdata),
        .out_last            (m_axis_tlast),
        .out_status          (status)
    );

    assign m_axis_tuser = status;

    // an error or truncation status only ever ends a walk
    a_status_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> m_axis_tlast)
        else $error("nonzero status on a result that is not last");

    // an out-of-store result carries cluster zero
    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STATUS_OOB) |-> (m_axis_tdata == 16'h0000))
        else $error("out-of-store result with nonzero cluster");

    // a walk taken from the queue shows its start cluster on the next cycle
    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.kind == CMD_WALK)
        |=> m_axis_tvalid && (m_axis_tdata == $past(cmd.value)))
        else $error("start cluster not presented after walk dequeue");

endmodule
